// ----- sv/shg_pkg.sv -----
// Shared types and constants for the spatial hash grid neighbor search block.
`timescale 1ns / 1ps

package shg_pkg;

    // Storage sizes
    localparam int MAX_POINTS   = 1024;
    localparam int NUM_BUCKETS  = 1024;
    localparam int BUCKET_DEPTH = 8;
    localparam int PIDX_W       = $clog2(MAX_POINTS);
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
    localparam int FILL_W       = SLOT_W + 1;
    localparam int CNT_W        = PIDX_W + 1;

    // Field widths
    localparam int COORD_W = 32;
    localparam int RES_W   = 11;
    localparam int SPC_W   = 31;
    localparam int DIV_N   = COORD_W + 1;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_MATCH    = 2'd1,
        ST_NOMATCH  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_RES_X   = 2'd0,
        CFG_RES_Y   = 2'd1,
        CFG_RES_Z   = 2'd2,
        CFG_SPACING = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic [SPC_W-1:0]           radius;
    } shg_in_t;

    typedef struct packed {
        status_t                    status;
        logic [PIDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0]  found_x;
        logic signed [COORD_W-1:0]  found_y;
        logic signed [COORD_W-1:0]  found_z;
        logic                       last;
    } shg_out_t;

endpackage

// ----- sv/shg_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module shg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [shg_pkg::DIV_N-1:0]     dividend,
    input  logic [shg_pkg::SPC_W-1:0]     divisor,
    output logic [shg_pkg::DIV_N-1:0]     quotient,
    output logic [shg_pkg::SPC_W-1:0]     remainder,
    output logic                          done
);

    logic [shg_pkg::DIV_N-1:0] quo_reg;
    logic [shg_pkg::SPC_W-1:0] rem_reg;
    logic [shg_pkg::SPC_W-1:0] dvs_reg;
    logic [5:0]                cnt_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic [shg_pkg::SPC_W:0]   rem_sh;
    logic                      ge;

    // One trial subtraction per cycle.
    assign rem_sh = {rem_reg, quo_reg[shg_pkg::DIV_N-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(shg_pkg::DIV_N - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[shg_pkg::DIV_N-2:0], ge};
            rem_reg <= ge ? shg_pkg::SPC_W'(rem_sh - {1'b0, dvs_reg})
                          : rem_sh[shg_pkg::SPC_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- sv/spatial_hash_grid_neighbor_search.sv -----
// Top level: sequencer, point and bucket memories, shared multiplier and divider.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------
// item      | in        | start & !busy        | shg_in_t  (kind, pos, radius)
// result    | out       | result_valid, 1 cycle| shg_out_t (status .. last)
// config    | in        | cfg_we               | cfg_index, cfg_data
//
// After reset the bucket fill table is swept to zero; busy is high during the sweep.
// A clear sweeps the fill table again between its acceptance and its result.
// Insert: three floor divisions and three wraps on the shared divider, then hashing
// and update. Query: the same divisions and radius squaring, then for each of the
// eight visited cells a bucket lookup, a bounding-cube test per candidate and a
// distance test for those inside the cube, plus a final step. Results are one-cycle
// strobes; the receiver cannot stall them.

module spatial_hash_grid_neighbor_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  shg_pkg::shg_in_t            item,
    output logic                        result_valid,
    output shg_pkg::shg_out_t           result,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [shg_pkg::SPC_W-1:0]   cfg_data
);

    typedef enum logic [20:0] {
        S_INIT     = 21'h000001,
        S_IDLE     = 21'h000002,
        S_CLR      = 21'h000004,
        S_DIV_GO   = 21'h000008,
        S_DIV_WAIT = 21'h000010,
        S_MOD_GO   = 21'h000020,
        S_MOD_WAIT = 21'h000040,
        S_RAD      = 21'h000080,
        S_RAD_W    = 21'h000100,
        S_LIN1     = 21'h000200,
        S_LIN2     = 21'h000400,
        S_LIN3     = 21'h000800,
        S_FILL     = 21'h001000,
        S_ENT      = 21'h002000,
        S_PT       = 21'h004000,
        S_DIFF     = 21'h008000,
        S_SQ0      = 21'h010000,
        S_SQ1      = 21'h020000,
        S_SQ2      = 21'h040000,
        S_SQ3      = 21'h080000,
        S_FIN      = 21'h100000
    } state_t;

    localparam int CW = shg_pkg::COORD_W;
    localparam int RW = shg_pkg::RES_W;

    state_t                         state_reg;
    shg_pkg::shg_in_t               item_reg;
    logic [RW-1:0]                  res_x_reg, res_y_reg, res_z_reg;
    logic [shg_pkg::SPC_W-1:0]      spc_reg;
    logic [shg_pkg::CNT_W-1:0]      count_reg;
    logic [shg_pkg::BKT_W-1:0]      sweep_reg;
    logic [1:0]                     axis_reg;
    logic signed [CW-1:0]           cell_reg;
    logic [RW-1:0]                  w_reg [3];
    logic [2:0]                     up_reg;
    logic [61:0]                    r2_reg;
    logic [2:0]                     corner_reg;
    logic [shg_pkg::BKT_W-1:0]      bucket_reg;
    logic [shg_pkg::FILL_W-1:0]     fill_cnt_reg;
    logic [shg_pkg::SLOT_W-1:0]     slot_reg;
    logic [shg_pkg::PIDX_W-1:0]     idx_reg;
    logic [30:0]                    ax_reg, ay_reg, az_reg;
    logic [63:0]                    acc_reg;
    logic [63:0]                    prod_reg;
    logic                           pend_valid_reg;
    shg_pkg::shg_out_t              pend_reg;
    logic                           res_valid_reg;
    shg_pkg::shg_out_t              res_reg;

    // Memories and their registered read data
    logic [3*CW-1:0]                pt_mem   [shg_pkg::MAX_POINTS];
    logic [shg_pkg::PIDX_W-1:0]     ent_mem  [shg_pkg::NUM_BUCKETS*shg_pkg::BUCKET_DEPTH];
    logic [shg_pkg::FILL_W-1:0]     fill_mem [shg_pkg::NUM_BUCKETS];
    logic [3*CW-1:0]                pt_q;
    logic [shg_pkg::PIDX_W-1:0]     ent_q;
    logic [shg_pkg::FILL_W-1:0]     fill_q;

    // Shared divider
    logic                           div_start;
    logic [shg_pkg::DIV_N-1:0]      div_dividend;
    logic [shg_pkg::SPC_W-1:0]      div_divisor;
    logic [shg_pkg::DIV_N-1:0]      div_quo;
    logic [shg_pkg::SPC_W-1:0]      div_rem;
    logic                           div_done;

    // Combinational helpers
    logic [RW-1:0]                  rx_eff, ry_eff, rz_eff, res_axis;
    logic [shg_pkg::SPC_W-1:0]      spc_eff;
    logic signed [CW-1:0]           pos_axis;
    logic [CW:0]                    pos_ext;
    logic [RW-1:0]                  wx_s, wy_s, wz_s;
    logic [31:0]                    mul_a, mul_b;
    logic [shg_pkg::BKT_W-1:0]      lin_addr;
    logic [shg_pkg::BKT_W-1:0]      lin_t;
    logic                           ins_full;
    logic                           ins_ok;
    logic                           fill_we;
    logic [shg_pkg::BKT_W-1:0]      fill_waddr;
    logic [shg_pkg::FILL_W-1:0]     fill_wdata;
    logic signed [CW:0]             dx, dy, dz;
    logic [CW:0]                    adx, ady, adz;
    logic [CW:0]                    rad_ext;
    logic signed [CW-1:0]           cx_new;
    logic [shg_pkg::SPC_W-1:0]      rf_new;
    logic [CW:0]                    cell_ext;
    logic [RW-1:0]                  m_new;
    logic [63:0]                    dist_sum;
    logic                           slot_last;
    logic                           corner_last;

    // A zero register value acts as one.
    function automatic logic [RW-1:0] eff_res(input logic [RW-1:0] r);
        eff_res = (r == '0) ? RW'(1) : r;
    endfunction

    // Cell coordinate of the origin or of its neighbor, wrapped into [0, r).
    function automatic logic [RW-1:0] nb_cell(input logic [RW-1:0] w, input logic up,
                                              input logic [RW-1:0] r, input logic use_nb);
        logic [RW-1:0] v;
        v = w;
        if (use_nb)
        begin
            if (up)
                v = (w + RW'(1) == r) ? '0 : w + RW'(1);
            else
                v = (w == '0) ? r - RW'(1) : w - RW'(1);
        end
        nb_cell = v;
    endfunction

    assign rx_eff  = eff_res(res_x_reg);
    assign ry_eff  = eff_res(res_y_reg);
    assign rz_eff  = eff_res(res_z_reg);
    assign spc_eff = (spc_reg == '0) ? shg_pkg::SPC_W'(1) : spc_reg;

    // Per-axis selection for the divide and wrap steps.
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin pos_axis = item_reg.pos_x; res_axis = rx_eff; end
            2'd1:    begin pos_axis = item_reg.pos_y; res_axis = ry_eff; end
            default: begin pos_axis = item_reg.pos_z; res_axis = rz_eff; end
        endcase
    end

    // Floor division from the magnitude quotient and remainder.
    assign pos_ext = {pos_axis[CW-1], pos_axis};
    always_comb
    begin
        if (!pos_axis[CW-1])
        begin
            cx_new = div_quo[CW-1:0];
            rf_new = div_rem;
        end
        else if (div_rem != '0)
        begin
            cx_new = ~div_quo[CW-1:0];
            rf_new = spc_eff - div_rem;
        end
        else
        begin
            cx_new = -div_quo[CW-1:0];
            rf_new = '0;
        end
    end

    // Wrap of the cell index: remainder corrected for negative cells.
    assign cell_ext = {cell_reg[CW-1], cell_reg};
    assign m_new    = div_rem[RW-1:0];

    // Divider operands
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = pos_ext[CW] ? (~pos_ext + 1'b1) : pos_ext;
        div_divisor  = spc_eff;
        case (state_reg)
            S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            S_MOD_GO:
            begin
                div_start    = 1'b1;
                div_dividend = cell_ext[CW] ? (~cell_ext + 1'b1) : cell_ext;
                div_divisor  = shg_pkg::SPC_W'(res_axis);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    shg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Cell of the current corner of the query box.
    assign wx_s = nb_cell(w_reg[0], up_reg[0], rx_eff, corner_reg[2]);
    assign wy_s = nb_cell(w_reg[1], up_reg[1], ry_eff, corner_reg[1]);
    assign wz_s = nb_cell(w_reg[2], up_reg[2], rz_eff, corner_reg[0]);

    // Linear bucket number, kept modulo the bucket count.
    assign lin_t    = prod_reg[shg_pkg::BKT_W-1:0] + wy_s[shg_pkg::BKT_W-1:0];
    assign lin_addr = prod_reg[shg_pkg::BKT_W-1:0] + wx_s[shg_pkg::BKT_W-1:0];

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            S_RAD:   begin mul_a = {1'b0, item_reg.radius}; mul_b = {1'b0, item_reg.radius}; end
            S_LIN1:  begin mul_a = 32'(wz_s); mul_b = 32'(ry_eff); end
            S_LIN2:  begin mul_a = 32'(lin_t); mul_b = 32'(rx_eff); end
            S_SQ0:   begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ax_reg}; end
            S_SQ1:   begin mul_a = {1'b0, ay_reg}; mul_b = {1'b0, ay_reg}; end
            S_SQ2:   begin mul_a = {1'b0, az_reg}; mul_b = {1'b0, az_reg}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Distance terms of the candidate point.
    assign dx  = {pt_q[3*CW-1], pt_q[3*CW-1:2*CW]} - {item_reg.pos_x[CW-1], item_reg.pos_x};
    assign dy  = {pt_q[2*CW-1], pt_q[2*CW-1:CW]} - {item_reg.pos_y[CW-1], item_reg.pos_y};
    assign dz  = {pt_q[CW-1], pt_q[CW-1:0]} - {item_reg.pos_z[CW-1], item_reg.pos_z};
    assign adx = dx[CW] ? (CW+1)'(0) - dx : dx;
    assign ady = dy[CW] ? (CW+1)'(0) - dy : dy;
    assign adz = dz[CW] ? (CW+1)'(0) - dz : dz;
    assign rad_ext  = {2'b00, item_reg.radius};
    assign dist_sum = acc_reg + prod_reg;

    assign slot_last   = ({1'b0, slot_reg} + 1'b1) == fill_cnt_reg;
    assign corner_last = corner_reg == 3'd7;

    // Insert decision and memory write enables.
    assign ins_full = count_reg[shg_pkg::CNT_W-1] || fill_q[shg_pkg::FILL_W-1];
    assign ins_ok   = (state_reg == S_FILL) && (item_reg.kind == shg_pkg::KIND_INSERT)
                      && !ins_full;
    assign fill_we  = ins_ok || (state_reg == S_CLR) || (state_reg == S_INIT);
    assign fill_waddr = ins_ok ? bucket_reg : sweep_reg;
    assign fill_wdata = ins_ok ? fill_q + 1'b1 : '0;

    // Point store
    always_ff @(posedge clk)
    begin
        if (ins_ok)
            pt_mem[count_reg[shg_pkg::PIDX_W-1:0]] <=
                {item_reg.pos_x, item_reg.pos_y, item_reg.pos_z};
        pt_q <= pt_mem[ent_q];
    end

    // Bucket entries
    always_ff @(posedge clk)
    begin
        if (ins_ok)
            ent_mem[{bucket_reg, fill_q[shg_pkg::SLOT_W-1:0]}] <=
                count_reg[shg_pkg::PIDX_W-1:0];
        ent_q <= ent_mem[{bucket_reg, slot_reg}];
    end

    // Bucket fill counts
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        fill_q <= fill_mem[lin_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_x_reg <= RW'(8);
            res_y_reg <= RW'(8);
            res_z_reg <= RW'(8);
            spc_reg   <= shg_pkg::SPC_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                shg_pkg::CFG_RES_X:   res_x_reg <= cfg_data[RW-1:0];
                shg_pkg::CFG_RES_Y:   res_y_reg <= cfg_data[RW-1:0];
                shg_pkg::CFG_RES_Z:   res_z_reg <= cfg_data[RW-1:0];
                shg_pkg::CFG_SPACING: spc_reg   <= cfg_data;
                default:              spc_reg   <= spc_reg;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sweep_reg      <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            axis_reg       <= '0;
            corner_reg     <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg       <= item;
                        axis_reg       <= '0;
                        sweep_reg      <= '0;
                        pend_valid_reg <= 1'b0;
                        case (item.kind)
                            shg_pkg::KIND_CLEAR:  state_reg <= S_CLR;
                            shg_pkg::KIND_INSERT: state_reg <= S_DIV_GO;
                            shg_pkg::KIND_QUERY:  state_reg <= S_DIV_GO;
                            default:              state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CLR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        count_reg     <= '0;
                        res_valid_reg <= 1'b1;
                        res_reg       <= '{status: shg_pkg::ST_DONE, point_index: '0,
                                           found_x: '0, found_y: '0, found_z: '0, last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        cell_reg         <= cx_new;
                        up_reg[axis_reg] <= {rf_new, 1'b0} >= {1'b0, spc_eff};
                        state_reg        <= S_MOD_GO;
                    end
                end
                S_MOD_GO:
                begin
                    state_reg <= S_MOD_WAIT;
                end
                S_MOD_WAIT:
                begin
                    if (div_done)
                    begin
                        w_reg[axis_reg] <= (cell_reg[CW-1] && m_new != '0) ? res_axis - m_new
                                                                          : m_new;
                        if (axis_reg == 2'd2)
                        begin
                            corner_reg <= '0;
                            state_reg  <= (item_reg.kind == shg_pkg::KIND_QUERY) ? S_RAD
                                                                                 : S_LIN1;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_RAD:
                begin
                    state_reg <= S_RAD_W;
                end
                S_RAD_W:
                begin
                    r2_reg    <= prod_reg[61:0];
                    state_reg <= S_LIN1;
                end
                S_LIN1:
                begin
                    state_reg <= S_LIN2;
                end
                S_LIN2:
                begin
                    state_reg <= S_LIN3;
                end
                S_LIN3:
                begin
                    bucket_reg <= lin_addr;
                    state_reg  <= S_FILL;
                end
                S_FILL:
                begin
                    if (item_reg.kind == shg_pkg::KIND_INSERT)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (ins_full)
                        begin
                            res_reg <= '{status: shg_pkg::ST_OVERFLOW, point_index: '0,
                                         found_x: '0, found_y: '0, found_z: '0, last: 1'b1};
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                            res_reg   <= '{status: shg_pkg::ST_DONE,
                                           point_index: count_reg[shg_pkg::PIDX_W-1:0],
                                           found_x: '0, found_y: '0, found_z: '0, last: 1'b1};
                        end
                    end
                    else
                    begin
                        fill_cnt_reg <= fill_q;
                        slot_reg     <= '0;
                        if (fill_q != '0)
                            state_reg <= S_ENT;
                        else if (corner_last)
                            state_reg <= S_FIN;
                        else
                        begin
                            corner_reg <= corner_reg + 3'd1;
                            state_reg  <= S_LIN1;
                        end
                    end
                end
                S_ENT:
                begin
                    state_reg <= S_PT;
                end
                S_PT:
                begin
                    idx_reg   <= ent_q;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    ax_reg <= adx[30:0];
                    ay_reg <= ady[30:0];
                    az_reg <= adz[30:0];
                    if (adx > rad_ext || ady > rad_ext || adz > rad_ext)
                    begin
                        // Outside the bounding cube: next candidate.
                        if (!slot_last)
                        begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= S_ENT;
                        end
                        else if (corner_last)
                            state_reg <= S_FIN;
                        else
                        begin
                            corner_reg <= corner_reg + 3'd1;
                            state_reg  <= S_LIN1;
                        end
                    end
                    else
                        state_reg <= S_SQ0;
                end
                S_SQ0:
                begin
                    state_reg <= S_SQ1;
                end
                S_SQ1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SQ2;
                end
                S_SQ2:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= S_SQ3;
                end
                S_SQ3:
                begin
                    // A match is held back one step so the final one can carry last.
                    if (dist_sum <= {2'b00, r2_reg})
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg       <= pend_reg;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_reg       <= '{status: shg_pkg::ST_MATCH, point_index: idx_reg,
                                            found_x: pt_q[3*CW-1:2*CW],
                                            found_y: pt_q[2*CW-1:CW],
                                            found_z: pt_q[CW-1:0], last: 1'b0};
                    end
                    if (!slot_last)
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_ENT;
                    end
                    else if (corner_last)
                        state_reg <= S_FIN;
                    else
                    begin
                        corner_reg <= corner_reg + 3'd1;
                        state_reg  <= S_LIN1;
                    end
                end
                S_FIN:
                begin
                    res_valid_reg <= 1'b1;
                    if (pend_valid_reg)
                        res_reg <= '{status: pend_reg.status,
                                     point_index: pend_reg.point_index,
                                     found_x: pend_reg.found_x,
                                     found_y: pend_reg.found_y,
                                     found_z: pend_reg.found_z, last: 1'b1};
                    else
                        res_reg <= '{status: shg_pkg::ST_NOMATCH, point_index: '0,
                                     found_x: '0, found_y: '0, found_z: '0, last: 1'b1};
                    pend_valid_reg <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- bench/spatial_hash_grid_neighbor_search_tb.sv -----
// Self-checking testbench for the spatial hash grid neighbor search block.
`timescale 1ns / 1ps

module spatial_hash_grid_neighbor_search_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 60;

    // Holds a copy of the grid and the registers, and predicts each transaction.
    class grid_scoreboard;
        longint            rx, ry, rz, spacing;
        longint            px_mem[shg_pkg::MAX_POINTS];
        longint            py_mem[shg_pkg::MAX_POINTS];
        longint            pz_mem[shg_pkg::MAX_POINTS];
        int                slot_idx[shg_pkg::NUM_BUCKETS*shg_pkg::BUCKET_DEPTH];
        int                fill[shg_pkg::NUM_BUCKETS];
        int                count;
        shg_pkg::shg_out_t pending_results[$];
        int                errors;

        function new();
            rx = 8;
            ry = 8;
            rz = 8;
            spacing = 65536;
            count = 0;
            errors = 0;
            foreach (fill[i]) fill[i] = 0;
        endfunction

        function void write_reg(shg_pkg::cfg_idx_t idx, int unsigned val);
            longint r;
            r = val & 32'h7FF;
            if (r == 0) r = 1;
            case (idx)
                shg_pkg::CFG_RES_X:   rx = r;
                shg_pkg::CFG_RES_Y:   ry = r;
                shg_pkg::CFG_RES_Z:   rz = r;
                shg_pkg::CFG_SPACING:
                    spacing = ((val & 32'h7FFF_FFFF) == 0) ? 1 : (val & 32'h7FFF_FFFF);
                default: ;
            endcase
        endfunction

        function longint floor_cell(longint p);
            longint q;
            q = p / spacing;
            if ((p % spacing) != 0 && p < 0) q = q - 1;
            return q;
        endfunction

        function longint wrap_cell(longint c, longint r);
            longint m;
            m = c % r;
            if (m < 0) m = m + r;
            return m;
        endfunction

        function int bucket_of(longint cx, longint cy, longint cz);
            longint lin;
            lin = (wrap_cell(cz, rz) * ry + wrap_cell(cy, ry)) * rx + wrap_cell(cx, rx);
            return int'(lin % shg_pkg::NUM_BUCKETS);
        endfunction

        // Append one expected result at the tail of the queue.
        function void queue_result(shg_pkg::shg_out_t o);
            pending_results.insert(pending_results.size(), o);
        endfunction

        function void push_simple(shg_pkg::status_t st, int idx);
            shg_pkg::shg_out_t o;
            o = '0;
            o.status = st;
            o.point_index = idx[shg_pkg::PIDX_W-1:0];
            o.last = 1'b1;
            queue_result(o);
        endfunction

        // Predict the results of one accepted transaction.
        function void apply_item(shg_pkg::shg_in_t it);
            longint px, py, pz, cx, cy, cz, dx, dy, dz, d;
            longint unsigned rad, r2, ax, ay, az;
            int b, n, idx;
            shg_pkg::shg_out_t o;
            px = longint'(it.pos_x);
            py = longint'(it.pos_y);
            pz = longint'(it.pos_z);
            rad = it.radius;
            cx = floor_cell(px);
            cy = floor_cell(py);
            cz = floor_cell(pz);
            case (it.kind)
                shg_pkg::KIND_CLEAR:
                begin
                    count = 0;
                    foreach (fill[i]) fill[i] = 0;
                    push_simple(shg_pkg::ST_DONE, 0);
                end
                shg_pkg::KIND_INSERT:
                begin
                    b = bucket_of(cx, cy, cz);
                    if (count >= shg_pkg::MAX_POINTS || fill[b] >= shg_pkg::BUCKET_DEPTH)
                    begin
                        push_simple(shg_pkg::ST_OVERFLOW, 0);
                    end
                    else
                    begin
                        px_mem[count] = px;
                        py_mem[count] = py;
                        pz_mem[count] = pz;
                        slot_idx[b*shg_pkg::BUCKET_DEPTH + fill[b]] = count;
                        fill[b]++;
                        push_simple(shg_pkg::ST_DONE, count);
                        count++;
                    end
                end
                shg_pkg::KIND_QUERY:
                begin
                    // Step toward the nearer half cell on each axis.
                    dx = ((2*cx + 1) * spacing <= 2*px) ? 1 : -1;
                    dy = ((2*cy + 1) * spacing <= 2*py) ? 1 : -1;
                    dz = ((2*cz + 1) * spacing <= 2*pz) ? 1 : -1;
                    r2 = rad * rad;
                    n = 0;
                    for (int c = 0; c < 8; c++)
                    begin
                        b = bucket_of(cx + (c[2] ? dx : 0), cy + (c[1] ? dy : 0),
                                      cz + (c[0] ? dz : 0));
                        for (int j = 0; j < fill[b]; j++)
                        begin
                            idx = slot_idx[b*shg_pkg::BUCKET_DEPTH + j];
                            d = px_mem[idx] - px;
                            ax = (d < 0) ? -d : d;
                            d = py_mem[idx] - py;
                            ay = (d < 0) ? -d : d;
                            d = pz_mem[idx] - pz;
                            az = (d < 0) ? -d : d;
                            if (ax <= rad && ay <= rad && az <= rad &&
                                ax*ax + ay*ay + az*az <= r2 &&
                                n < 8*shg_pkg::BUCKET_DEPTH)
                            begin
                                o = '0;
                                o.status = shg_pkg::ST_MATCH;
                                o.point_index = idx[shg_pkg::PIDX_W-1:0];
                                o.found_x = px_mem[idx][31:0];
                                o.found_y = py_mem[idx][31:0];
                                o.found_z = pz_mem[idx][31:0];
                                queue_result(o);
                                n++;
                            end
                        end
                    end
                    if (n == 0)
                        push_simple(shg_pkg::ST_NOMATCH, 0);
                    else
                        pending_results[pending_results.size()-1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        // Compare one result with the oldest expectation.
        task check_result(shg_pkg::shg_out_t r);
            shg_pkg::shg_out_t e;
            if (pending_results.size() == 0)
            begin
                report("result with no pending expectation");
                return;
            end
            e = pending_results.pop_front();
            if (r.status != e.status)
                report($sformatf("status %0d, expected %0d", r.status, e.status));
            if (r.point_index != e.point_index)
                report($sformatf("point_index %0d, expected %0d", r.point_index, e.point_index));
            if (r.found_x != e.found_x)
                report($sformatf("found_x %h, expected %h", r.found_x, e.found_x));
            if (r.found_y != e.found_y)
                report($sformatf("found_y %h, expected %h", r.found_y, e.found_y));
            if (r.found_z != e.found_z)
                report($sformatf("found_z %h, expected %h", r.found_z, e.found_z));
            if (r.last != e.last)
                report($sformatf("last %0d, expected %0d", r.last, e.last));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    shg_pkg::shg_in_t            item = '0;
    logic                        result_valid;
    shg_pkg::shg_out_t           result;
    logic                        cfg_we = 1'b0;
    logic [1:0]                  cfg_index = '0;
    logic [shg_pkg::SPC_W-1:0]   cfg_data = '0;

    grid_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;

    spatial_hash_grid_neighbor_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Check every result transaction as it is strobed.
    always @(posedge clk)
    begin
        if (result_valid) sb.check_result(result);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL spatial_hash_grid_neighbor_search");
            $finish;
        end
    end

    function automatic shg_pkg::shg_in_t mk(shg_pkg::kind_t k, int x, int y, int z,
                                            int unsigned r);
        shg_pkg::shg_in_t it;
        it.kind = k;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.radius = r[shg_pkg::SPC_W-1:0];
        return it;
    endfunction

    // Send one transaction, with bursts and random gaps between them.
    task send_item(shg_pkg::shg_in_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        while (busy) @(negedge clk);
        item = it;
        start = 1'b1;
        sb.apply_item(it);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Wait until the block is idle and nothing is pending.
    task wait_idle();
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task write_cfg(shg_pkg::cfg_idx_t idx, int unsigned val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[shg_pkg::SPC_W-1:0];
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task set_grid(int unsigned x, int unsigned y, int unsigned z, int unsigned s);
        write_cfg(shg_pkg::CFG_RES_X, x);
        write_cfg(shg_pkg::CFG_RES_Y, y);
        write_cfg(shg_pkg::CFG_RES_Z, z);
        write_cfg(shg_pkg::CFG_SPACING, s);
    endtask

    // A coordinate near a center, truncated to 32 bits.
    function automatic int near(int center, longint unsigned span);
        longint v;
        v = longint'(center) + longint'($urandom_range(0, int'(span))) - longint'(span / 2);
        return int'(v[31:0]);
    endfunction

    // One random phase: clustered inserts, queries and occasional clears and kind-three items, with some noise.
    task random_phase(int n_items);
        longint unsigned span;
        int cx, cy, cz;
        int unsigned sel, rad;
        shg_pkg::kind_t k;
        span = sb.spacing * 3 + 8;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55) k = shg_pkg::KIND_INSERT;
            else if (sel < 93) k = shg_pkg::KIND_QUERY;
            else if (sel < 96) k = shg_pkg::KIND_CLEAR;
            else k = shg_pkg::KIND_NONE;
            case ($urandom_range(0, 3))
                0: rad = 0;
                1: rad = $urandom_range(0, int'(span));
                2: rad = span[31:0];
                default: rad = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
                send_item(mk(k, $urandom, $urandom, $urandom, $urandom));
            else
                send_item(mk(k, near(cx, span), near(cy, span), near(cz, span), rad));
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        while (busy) @(negedge clk);

        // Directed: empty store, coordinate extremes, full bucket, kind three.
        send_item(mk(shg_pkg::KIND_QUERY, 0, 0, 0, 32'h7FFF_FFFF));
        send_item(mk(shg_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        send_item(mk(shg_pkg::KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
        send_item(mk(shg_pkg::KIND_INSERT, -1, 0, 32'h0000_8000, 0));
        for (int i = 0; i < 9; i++) send_item(mk(shg_pkg::KIND_INSERT, 100, 200, 300, 0));
        send_item(mk(shg_pkg::KIND_QUERY, 100, 200, 300, 0));
        send_item(mk(shg_pkg::KIND_QUERY, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(mk(shg_pkg::KIND_QUERY, -1, 32'h0000_8000, 32'h0000_7FFF, 32'h0001_0000));
        send_item(mk(shg_pkg::KIND_NONE, 1, 2, 3, 4));
        send_item(mk(shg_pkg::KIND_CLEAR, 0, 0, 0, 0));
        send_item(mk(shg_pkg::KIND_QUERY, 100, 200, 300, 32'h7FFF_FFFF));

        // Resolution one: wrapped neighbor cells repeat matches.
        set_grid(1, 1, 1, 32'h0001_0000);
        send_item(mk(shg_pkg::KIND_INSERT, 10, 20, 30, 0));
        send_item(mk(shg_pkg::KIND_INSERT, -10, -20, -30, 0));
        send_item(mk(shg_pkg::KIND_QUERY, 0, 0, 0, 100));

        // Random phases over a spread of grid settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_grid(8, 8, 8, 32'h0001_0000);
                1: set_grid(1, 1, 1, 1);
                2: set_grid(1024, 1024, 1024, 32'h7FFF_FFFF);
                3: set_grid(0, 0, 0, 0);
                4: set_grid(2047, 3, 1024, $urandom_range(1, 256));
                default: set_grid($urandom_range(0, 2047) | ($urandom << 11),
                                  $urandom_range(1, 64), $urandom_range(1, 16),
                                  $urandom_range(1, 32'h0010_0000));
            endcase
            if (ph % 2 == 0)
                send_item(mk(shg_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
            random_phase(55);
        end

        // Two buckets only, so that inserts overflow.
        send_item(mk(shg_pkg::KIND_CLEAR, 0, 0, 0, 0));
        set_grid(2, 1, 1, 32'h0001_0000);
        for (int i = 0; i < 20; i++)
            send_item(mk(shg_pkg::KIND_INSERT, $urandom, $urandom, $urandom, $urandom));
        send_item(mk(shg_pkg::KIND_QUERY, 0, 0, 0, 32'h7FFF_FFFF));

        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.errors == 0)
            $display("PASS spatial_hash_grid_neighbor_search");
        else
            $display("FAIL spatial_hash_grid_neighbor_search");
        $finish;
    end

endmodule
